@@ rtl/assert_macros.svh @@
// Assertion macros for the segment builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while out of reset.
`define DSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check a property that must also hold during reset.
`define DSG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/dsg_pkg.sv @@
// Shared types and constants of the scatter/gather segment builder.
`timescale 1ns / 1ps
`default_nettype none

package dsg_pkg;

  localparam int unsigned PAGE_BYTES    = 8192;
  localparam int unsigned PAGE_BITS     = 13;
  localparam int unsigned ADDR_BITS     = 48;
  localparam int unsigned LEN_W         = 14;
  localparam int unsigned SEG_LEN_W     = 32;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned MAXSEG_W      = 13;
  localparam int unsigned BSHIFT_W      = 6;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned MAX_STEP_SEGS = 16;
  localparam int unsigned MIN_BSHIFT    = 9;
  localparam int unsigned MAX_SEGS_CAP  = 4096;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEG_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENTS   = 2'd2;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] phys_addr;
    logic [LEN_W-1:0]     frag_len;
    logic                 first;
    logic                 end_of_load;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] seg_addr;
    logic [SEG_LEN_W-1:0] seg_len;
    logic [IDX_W-1:0]     seg_index;
    logic                 last;
    logic                 status;
  } out_item_t;

  typedef struct packed {
    logic [BSHIFT_W-1:0]  boundary_shift;
    logic [SEG_LEN_W-1:0] max_seg_len;
    logic [MAXSEG_W-1:0]  max_segments;
  } cfg_t;

  // Outcome of one pass through the shared piece unit
  typedef struct packed {
    logic [LEN_W-1:0]     piece;
    logic [ADDR_BITS-1:0] next_addr;
    logic [LEN_W-1:0]     rem_next;
    logic                 merge;
  } piece_res_t;

endpackage

`default_nettype wire

@@ rtl/dsg_piece_unit.sv @@
// Shared piece unit: boundary cut, next address and merge check for one piece.
`timescale 1ns / 1ps
`default_nettype none

module dsg_piece_unit (
  input  wire dsg_pkg::cfg_t                  cfg_i,
  input  wire logic [dsg_pkg::ADDR_BITS-1:0]  cur_addr_i,
  input  wire logic [dsg_pkg::LEN_W-1:0]      rem_len_i,
  input  wire logic [dsg_pkg::ADDR_BITS-1:0]  open_addr_i,
  input  wire logic [dsg_pkg::SEG_LEN_W-1:0]  open_len_i,
  input  wire logic [dsg_pkg::ADDR_BITS-1:0]  next_exp_i,
  output dsg_pkg::piece_res_t                 res_o
);

  logic [dsg_pkg::BSHIFT_W-1:0]  b_eff;
  logic                          bnd;
  logic [dsg_pkg::ADDR_BITS-1:0] low_mask;
  logic [dsg_pkg::ADDR_BITS-1:0] to_b;
  logic [dsg_pkg::LEN_W-1:0]     piece;
  logic [dsg_pkg::SEG_LEN_W:0]   len_sum;
  logic                          same_win;

  // Derive the effective boundary window
  always_comb begin
    b_eff = cfg_i.boundary_shift;
    if ((cfg_i.boundary_shift != '0) &&
        (cfg_i.boundary_shift < dsg_pkg::BSHIFT_W'(dsg_pkg::MIN_BSHIFT))) begin
      b_eff = dsg_pkg::BSHIFT_W'(dsg_pkg::MIN_BSHIFT);
    end
    bnd = (b_eff != '0) && (b_eff < dsg_pkg::BSHIFT_W'(dsg_pkg::ADDR_BITS));
    low_mask = bnd ? ((dsg_pkg::ADDR_BITS'(1) << b_eff) - dsg_pkg::ADDR_BITS'(1))
                   : '1;
  end

  // Cut the piece at the next boundary
  always_comb begin
    to_b  = (~cur_addr_i & low_mask) + dsg_pkg::ADDR_BITS'(1);
    piece = rem_len_i;
    if (bnd && (to_b < dsg_pkg::ADDR_BITS'(rem_len_i))) begin
      piece = to_b[dsg_pkg::LEN_W-1:0];
    end
  end

  // Check contiguity, length and window for a merge
  always_comb begin
    len_sum  = {1'b0, open_len_i} + (dsg_pkg::SEG_LEN_W + 1)'(piece);
    same_win = !bnd || (((open_addr_i ^ cur_addr_i) & ~low_mask) == '0);
    res_o.piece     = piece;
    res_o.next_addr = cur_addr_i + dsg_pkg::ADDR_BITS'(piece);
    res_o.rem_next  = rem_len_i - piece;
    res_o.merge     = (cur_addr_i == next_exp_i) &&
                      (len_sum <= {1'b0, cfg_i.max_seg_len}) && same_win;
  end

endmodule

`default_nettype wire

@@ rtl/dsg_out_reg.sv @@
// Output register: holds one result until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module dsg_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire dsg_pkg::out_item_t push_data_i,
  output logic                    space_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dsg_pkg::out_item_t      out_data_o
);

  logic               valid_q;
  dsg_pkg::out_item_t data_q;

  assign space_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i && space_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load the payload
  always_ff @(posedge clk_i) begin
    if (push_i && space_o) begin
      data_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dsg_seq.sv @@
// Sequencer: walks one fragment piece by piece and keeps the open segment.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dsg_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dsg_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  input  wire dsg_pkg::in_item_t  in_data_i,
  output logic                    in_stall_o,
  input  wire logic               space_i,
  output logic                    push_o,
  output dsg_pkg::out_item_t      push_data_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PIECE = 2'd1;
  localparam logic [1:0] S_EOL   = 2'd2;

  logic [1:0]                     state_q, state_d;
  logic [dsg_pkg::ADDR_BITS-1:0]  cur_addr_q, cur_addr_d;
  logic [dsg_pkg::LEN_W-1:0]      rem_len_q, rem_len_d;
  logic                           eol_q, eol_d;
  logic [dsg_pkg::CNT_W-1:0]      n_q, n_d;
  logic [dsg_pkg::ADDR_BITS-1:0]  open_addr_q, open_addr_d;
  logic [dsg_pkg::SEG_LEN_W-1:0]  open_len_q, open_len_d;
  logic [dsg_pkg::ADDR_BITS-1:0]  next_exp_q, next_exp_d;
  logic [dsg_pkg::IDX_W-1:0]      index_q, index_d;
  logic                           failed_q, failed_d;
  logic                           open_q, open_d;

  dsg_pkg::piece_res_t            pr;
  logic [dsg_pkg::LEN_W-1:0]      room;
  logic [dsg_pkg::LEN_W-1:0]      clamp_len;
  logic [dsg_pkg::MAXSEG_W-1:0]   lim;
  logic                           too_many;
  logic                           restart;

  dsg_piece_unit u_piece (
    .cfg_i       (cfg_i),
    .cur_addr_i  (cur_addr_q),
    .rem_len_i   (rem_len_q),
    .open_addr_i (open_addr_q),
    .open_len_i  (open_len_q),
    .next_exp_i  (next_exp_q),
    .res_o       (pr)
  );

  assign in_stall_o = (state_q != S_IDLE);

  // Clamp the fragment at its page end, check the segment limits, detect a restart
  always_comb begin
    room = dsg_pkg::LEN_W'(dsg_pkg::PAGE_BYTES) -
           dsg_pkg::LEN_W'(in_data_i.phys_addr[dsg_pkg::PAGE_BITS-1:0]);
    clamp_len = (in_data_i.frag_len > room) ? room : in_data_i.frag_len;
    lim = (cfg_i.max_segments > dsg_pkg::MAXSEG_W'(dsg_pkg::MAX_SEGS_CAP))
          ? dsg_pkg::MAXSEG_W'(dsg_pkg::MAX_SEGS_CAP) : cfg_i.max_segments;
    too_many = ((dsg_pkg::MAXSEG_W'(index_q) + dsg_pkg::MAXSEG_W'(1)) >= lim) ||
               (n_q >= dsg_pkg::CNT_W'(dsg_pkg::MAX_STEP_SEGS));
    restart = in_data_i.first || (!failed_q && !open_q);
  end

  // Sequence pieces, emit segments
  always_comb begin
    state_d     = state_q;
    cur_addr_d  = cur_addr_q;
    rem_len_d   = rem_len_q;
    eol_d       = eol_q;
    n_d         = n_q;
    open_addr_d = open_addr_q;
    open_len_d  = open_len_q;
    next_exp_d  = next_exp_q;
    index_d     = index_q;
    failed_d    = failed_q;
    open_d      = open_q;
    push_o      = 1'b0;
    push_data_o = '{seg_addr: open_addr_q, seg_len: open_len_q, seg_index: index_q,
                    last: 1'b0, status: dsg_pkg::STATUS_OK};

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (restart) begin
            index_d     = '0;
            failed_d    = 1'b0;
            open_d      = 1'b0;
            open_addr_d = '0;
            open_len_d  = '0;
          end
          // A failed load drops fragments until the next first
          if (restart || !failed_q) begin
            cur_addr_d = in_data_i.phys_addr;
            rem_len_d  = clamp_len;
            eol_d      = in_data_i.end_of_load;
            n_d        = '0;
            if (clamp_len != '0) begin
              state_d = S_PIECE;
            end else if (in_data_i.end_of_load) begin
              state_d = S_EOL;
            end
          end
        end
      end

      S_PIECE: begin
        if (!open_q || pr.merge || space_i) begin
          if (!open_q) begin
            open_addr_d = cur_addr_q;
            open_len_d  = dsg_pkg::SEG_LEN_W'(pr.piece);
            open_d      = 1'b1;
          end else if (pr.merge) begin
            open_len_d  = open_len_q + dsg_pkg::SEG_LEN_W'(pr.piece);
          end else begin
            push_o = 1'b1;
            if (too_many) begin
              push_data_o = '{seg_addr: '0, seg_len: '0, seg_index: index_q,
                              last: 1'b1, status: dsg_pkg::STATUS_FAIL};
            end else begin
              index_d     = index_q + dsg_pkg::IDX_W'(1);
              n_d         = n_q + dsg_pkg::CNT_W'(1);
              open_addr_d = cur_addr_q;
              open_len_d  = dsg_pkg::SEG_LEN_W'(pr.piece);
            end
          end

          if (open_q && !pr.merge && too_many) begin
            // Fail the load and drop the open segment
            failed_d    = 1'b1;
            open_d      = 1'b0;
            open_addr_d = '0;
            open_len_d  = '0;
            state_d     = S_IDLE;
          end else begin
            cur_addr_d = pr.next_addr;
            next_exp_d = pr.next_addr;
            rem_len_d  = pr.rem_next;
            if (pr.rem_next == '0) begin
              state_d = eol_q ? S_EOL : S_IDLE;
            end
          end
        end
      end

      S_EOL: begin
        if (space_i) begin
          push_o = 1'b1;
          push_data_o = '{seg_addr: open_q ? open_addr_q : '0,
                          seg_len: open_q ? open_len_q : '0,
                          seg_index: index_q, last: 1'b1,
                          status: dsg_pkg::STATUS_OK};
          open_d      = 1'b0;
          index_d     = '0;
          open_addr_d = '0;
          open_len_d  = '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold sequencer and segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_addr_q  <= '0;
      rem_len_q   <= '0;
      eol_q       <= 1'b0;
      n_q         <= '0;
      open_addr_q <= '0;
      open_len_q  <= '0;
      next_exp_q  <= '0;
      index_q     <= '0;
      failed_q    <= 1'b0;
      open_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_addr_q  <= cur_addr_d;
      rem_len_q   <= rem_len_d;
      eol_q       <= eol_d;
      n_q         <= n_d;
      open_addr_q <= open_addr_d;
      open_len_q  <= open_len_d;
      next_exp_q  <= next_exp_d;
      index_q     <= index_d;
      failed_q    <= failed_d;
      open_q      <= open_d;
    end
  end

  `DSG_ASSERT(a_piece_has_bytes, (state_q == S_PIECE) |-> (rem_len_q != '0), "piece state with no bytes left")
  `DSG_ASSERT(a_fail_closes, (push_o && (push_data_o.status == dsg_pkg::STATUS_FAIL)) |=> (failed_q && !open_q && (state_q == S_IDLE)), "failure did not close the load")
  `DSG_ASSERT(a_eol_resets, ((state_q == S_EOL) && space_i) |=> ((index_q == '0) && !open_q && (state_q == S_IDLE)), "end of load left state behind")
  `DSG_ASSERT_ALWAYS(a_fail_is_last, (push_o && (push_data_o.status == dsg_pkg::STATUS_FAIL)) |-> push_data_o.last, "failure result without last")

endmodule

`default_nettype wire

@@ rtl/dma_scatter_gather_segment_builder.sv @@
// A fragment is taken while the sequencer is idle and cut into boundary pieces
// (1 to 16), one per cycle while no finished segment waits on a stalled output
// register; an end-of-load result follows the last piece. Each result shows in
// the output register the cycle after it is formed. A new fragment is held off
// until the last is done; all share one piece unit. Reset (rst_ni low, async)
// empties the output, closes any segment and restores defaults 0, 2^32-1, 4096.
`timescale 1ns / 1ps
`default_nettype none

module dma_scatter_gather_segment_builder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dsg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dsg_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire dsg_pkg::in_item_t               in_data_i,
  output logic                                 in_stall_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output dsg_pkg::out_item_t                   out_data_o
);

  dsg_pkg::cfg_t      cfg_q;
  logic               push;
  logic               space;
  dsg_pkg::out_item_t push_data;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boundary_shift <= '0;
      cfg_q.max_seg_len    <= '1;
      cfg_q.max_segments   <= dsg_pkg::MAXSEG_W'(dsg_pkg::MAX_SEGS_CAP);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsg_pkg::REG_BOUNDARY_SHIFT: begin
          cfg_q.boundary_shift <= cfg_wdata_i[dsg_pkg::BSHIFT_W-1:0];
        end
        dsg_pkg::REG_MAX_SEG_LEN: begin
          cfg_q.max_seg_len <= cfg_wdata_i[dsg_pkg::SEG_LEN_W-1:0];
        end
        dsg_pkg::REG_MAX_SEGMENTS: begin
          cfg_q.max_segments <= cfg_wdata_i[dsg_pkg::MAXSEG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  dsg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .space_i     (space),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dsg_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the DMA scatter/gather segment builder.
`timescale 1ns / 1ps

module testbench;
  import dsg_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_AT       = 60;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_FRAGS   = 18;
  localparam int unsigned PHASES        = 7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  in_item_t              in_data_i = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;

  // Fragments waiting to be sent and segments waiting to come out
  in_item_t  frags_to_send [$];
  out_item_t segs_due [$];

  int unsigned frags_queued = 0;
  int unsigned frags_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        frag_taken = 1'b0;
  logic        quiet;

  // Register settings of the random phases
  logic [BSHIFT_W-1:0]  bshift_plan [0:PHASES-1] = '{6'd0, 6'd9, 6'd1, 6'd40, 6'd12, 6'd48,
                                                     6'd20};
  logic [SEG_LEN_W-1:0] seg_len_plan [0:PHASES-1] = '{32'hFFFF_FFFF, 32'd4096, 32'd1,
                                                      32'd65536, 32'd20000, 32'd3000,
                                                      32'd700};
  logic [MAXSEG_W-1:0]  seg_count_plan [0:PHASES-1] = '{13'd4096, 13'd64, 13'd1, 13'd8191,
                                                        13'd5, 13'd2, 13'd4097};

  // Mirror of the block's registers and segment state
  logic [BSHIFT_W-1:0]  bshift_cfg = '0;
  logic [SEG_LEN_W-1:0] seg_len_cap = '1;
  logic [MAXSEG_W-1:0]  seg_limit_cfg = 13'd4096;
  logic [ADDR_BITS-1:0] open_base = '0;
  logic [SEG_LEN_W-1:0] open_bytes = '0;
  logic [ADDR_BITS-1:0] next_addr_due = '0;
  logic [IDX_W-1:0]     seg_count = '0;
  logic                 load_dead = 1'b0;
  logic                 seg_live = 1'b0;

  dma_scatter_gather_segment_builder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // No idling on either side over a stretch of the random part
  assign quiet = (frags_accepted >= 100) && (frags_accepted < 130);

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic push_seg(input logic [ADDR_BITS-1:0] a, input logic [SEG_LEN_W-1:0] l,
                          input logic [IDX_W-1:0] idx, input logic lst, input logic st);
    out_item_t seg;
    seg.seg_addr  = a;
    seg.seg_len   = l;
    seg.seg_index = idx;
    seg.last      = lst;
    seg.status    = st;
    segs_due.push_back(seg);
  endtask

  // Clamp a fragment to its page, cut it at the boundary and merge or emit segments
  task automatic build_segments(input in_item_t frag);
    logic [ADDR_BITS-1:0] addr;
    logic [63:0]          left;
    logic [63:0]          room;
    logic [63:0]          piece;
    logic [63:0]          to_win;
    int unsigned          win;
    int unsigned          cap;
    int unsigned          emitted;
    logic                 windowed;
    addr    = frag.phys_addr;
    left    = 64'(frag.frag_len);
    emitted = 0;
    if (frag.first || (!load_dead && !seg_live)) begin
      seg_count  = '0;
      load_dead  = 1'b0;
      seg_live   = 1'b0;
      open_base  = '0;
      open_bytes = '0;
    end
    if (load_dead) return;
    win = 32'(bshift_cfg);
    if (win != 0 && win < MIN_BSHIFT) win = MIN_BSHIFT;
    windowed = (win != 0) && (win < ADDR_BITS);
    cap = (seg_limit_cfg > MAX_SEGS_CAP) ? MAX_SEGS_CAP : 32'(seg_limit_cfg);
    room = 64'(PAGE_BYTES - 32'(addr[PAGE_BITS-1:0]));
    if (left > room) left = room;
    while (left > 0) begin
      piece = left;
      if (windowed) begin
        to_win = (64'd1 << win) - (64'(addr) & ((64'd1 << win) - 64'd1));
        if (piece > to_win) piece = to_win;
      end
      if (!seg_live) begin
        open_base  = addr;
        open_bytes = SEG_LEN_W'(piece);
        seg_live   = 1'b1;
      end else if (addr == next_addr_due && 64'(open_bytes) + piece <= 64'(seg_len_cap) &&
                   (!windowed || (open_base >> win) == (addr >> win))) begin
        open_bytes = open_bytes + SEG_LEN_W'(piece);
      end else begin
        // Too many segments: report the failure and drop the rest of the load
        if (32'(seg_count) + 1 >= cap || emitted >= MAX_STEP_SEGS) begin
          push_seg('0, '0, seg_count, 1'b1, STATUS_FAIL);
          load_dead  = 1'b1;
          seg_live   = 1'b0;
          open_base  = '0;
          open_bytes = '0;
          return;
        end
        push_seg(open_base, open_bytes, seg_count, 1'b0, STATUS_OK);
        emitted++;
        seg_count  = seg_count + 1'b1;
        open_base  = addr;
        open_bytes = SEG_LEN_W'(piece);
      end
      addr          = addr + ADDR_BITS'(piece);
      next_addr_due = addr;
      left          = left - piece;
    end
    if (frag.end_of_load) begin
      if (seg_live) push_seg(open_base, open_bytes, seg_count, 1'b1, STATUS_OK);
      else push_seg('0, '0, seg_count, 1'b1, STATUS_OK);
      seg_live   = 1'b0;
      seg_count  = '0;
      open_base  = '0;
      open_bytes = '0;
    end
  endtask

  task automatic queue_frag(input logic [ADDR_BITS-1:0] a, input logic [LEN_W-1:0] l,
                            input logic f, input logic e);
    in_item_t frag;
    frag.phys_addr   = a;
    frag.frag_len    = l;
    frag.first       = f;
    frag.end_of_load = e;
    frags_to_send.push_back(frag);
    frags_queued++;
  endtask

  // Queue one load: mostly contiguous fragments, with some broken markers
  task automatic queue_load();
    int unsigned          n;
    int unsigned          pick;
    logic [ADDR_BITS-1:0] a;
    logic [LEN_W-1:0]     l;
    logic [LEN_W-1:0]     room;
    logic                 f;
    logic                 e;
    n = $urandom_range(1, 6);
    a = ADDR_BITS'({$urandom, $urandom});
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (i == 0 || pick >= 65) begin
        a = ADDR_BITS'({$urandom, $urandom});
        if (pick[0]) a[PAGE_BITS-1:0] = PAGE_BITS'(32'h1FFF - $urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 60) l = LEN_W'($urandom_range(1, PAGE_BYTES));
      else if (pick < 85) l = LEN_W'($urandom_range(1, 600));
      else if (pick < 92) l = '0;
      else l = LEN_W'($urandom_range(PAGE_BYTES + 1, 16383));
      f = (i == 0);
      e = (i == n - 1);
      pick = $urandom_range(99);
      if (pick < 5) f = ~f;
      else if (pick < 10) e = ~e;
      queue_frag(a, l, f, e);
      room = LEN_W'(PAGE_BYTES) - LEN_W'(a[PAGE_BITS-1:0]);
      a = a + ADDR_BITS'((l > room) ? room : l);
    end
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_BOUNDARY_SHIFT: bshift_cfg = data[BSHIFT_W-1:0];
      REG_MAX_SEG_LEN:    seg_len_cap = data[SEG_LEN_W-1:0];
      REG_MAX_SEGMENTS:   seg_limit_cfg = data[MAXSEG_W-1:0];
      default: ;
    endcase
  endtask

  // Write all three registers on consecutive cycles, block idle
  task automatic set_regs(input logic [BSHIFT_W-1:0] bs, input logic [SEG_LEN_W-1:0] msl,
                          input logic [MAXSEG_W-1:0] ms);
    @(negedge clk_i);
    put_reg(REG_BOUNDARY_SHIFT, CFG_DATA_W'(bs));
    @(negedge clk_i);
    put_reg(REG_MAX_SEG_LEN, msl);
    @(negedge clk_i);
    put_reg(REG_MAX_SEGMENTS, CFG_DATA_W'(ms));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait for every queued fragment to go in and every segment to come out
  task automatic drain();
    while (frags_to_send.size() != 0 || in_valid_i || in_stall_o ||
           segs_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sender: offer the next fragment, hold a stalled one
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || frag_taken) begin
      if (frags_to_send.size() != 0 && (quiet || $urandom_range(99) >= 24)) begin
        in_data_i  <= frags_to_send.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off once the block is busy
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && frags_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
    out_stall_i <= (hold_left != 0) || (!quiet && $urandom_range(99) < 24);
  end

  // Predict the segments of each input transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      frag_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        build_segments(in_data_i);
        frags_accepted++;
      end
    end
  end

  // Check each output transfer against the oldest predicted segment
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (segs_due.size() == 0) begin
        report_mismatch("segment with none expected", 64'(out_data_o.seg_addr), '0);
      end else begin
        want = segs_due.pop_front();
        if (out_data_o.seg_addr !== want.seg_addr)
          report_mismatch("seg_addr", 64'(out_data_o.seg_addr), 64'(want.seg_addr));
        if (out_data_o.seg_len !== want.seg_len)
          report_mismatch("seg_len", 64'(out_data_o.seg_len), 64'(want.seg_len));
        if (out_data_o.seg_index !== want.seg_index)
          report_mismatch("seg_index", 64'(out_data_o.seg_index), 64'(want.seg_index));
        if (out_data_o.last !== want.last)
          report_mismatch("last", 64'(out_data_o.last), 64'(want.last));
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dma_scatter_gather_segment_builder test failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default registers: field extremes, merges, empty, abandoned and headless loads
    queue_frag(48'h0, 14'd1, 1'b1, 1'b1);
    queue_frag(48'h123, 14'd0, 1'b1, 1'b1);
    queue_frag(48'h1000, 14'd8192, 1'b1, 1'b0);
    queue_frag(48'h2000, 14'd8192, 1'b0, 1'b0);
    queue_frag(48'h1_0000, 14'd16383, 1'b0, 1'b1);
    queue_frag(48'h5_0000, 14'd100, 1'b1, 1'b0);
    queue_frag(48'h6_0000, 14'd100, 1'b1, 1'b1);
    queue_frag(48'h7_0000, 14'd64, 1'b0, 1'b1);
    queue_frag(48'hFFFF_FFFF_FFFF, 14'd8192, 1'b1, 1'b0);
    queue_frag(48'h0, 14'd16, 1'b0, 1'b0);
    queue_frag(48'hAAAA_AAAA_AAAA, 14'd8191, 1'b0, 1'b0);
    queue_frag(48'h5555_5555_5555, 14'd1, 1'b0, 1'b0);
    queue_frag(48'h5555_5555_5556, 14'd0, 1'b0, 1'b1);
    drain();

    // Smallest boundary: a full page cut into the most pieces, window splits
    set_regs(6'd9, 32'd4096, 13'd4096);
    queue_frag(48'h4000, 14'd100, 1'b1, 1'b0);
    queue_frag(48'h6000, 14'd8192, 1'b0, 1'b1);
    queue_frag(48'h100, 14'd256, 1'b1, 1'b0);
    queue_frag(48'h200, 14'd256, 1'b0, 1'b1);
    drain();

    // Length cap and too many segments, then a fresh load after the failure
    set_regs(6'd1, 32'd1000, 13'd3);
    queue_frag(48'h0, 14'd600, 1'b1, 1'b0);
    queue_frag(48'd600, 14'd600, 1'b0, 1'b0);
    queue_frag(48'h2_0000, 14'd10, 1'b0, 1'b0);
    queue_frag(48'h3_0000, 14'd10, 1'b0, 1'b1);
    queue_frag(48'h4_0000, 14'd10, 1'b1, 1'b1);
    drain();

    // Boundary beyond the address width, zero segment limit
    set_regs(6'd63, 32'hFFFF_FFFF, 13'd0);
    queue_frag(48'h8_0000, 14'd8192, 1'b1, 1'b1);
    queue_frag(48'h9_0000, 14'd8, 1'b1, 1'b0);
    queue_frag(48'hA_0000, 14'd8, 1'b0, 1'b1);
    drain();

    // Random loads under each register setting
    for (int unsigned p = 0; p < PHASES; p++) begin
      int unsigned stop_at;
      set_regs(bshift_plan[p], seg_len_plan[p], seg_count_plan[p]);
      stop_at = frags_queued + PHASE_FRAGS;
      while (frags_queued < stop_at) queue_load();
      drain();
    end

    if (mismatch_count == 0 && segs_due.size() == 0) begin
      $display("dma_scatter_gather_segment_builder test passed");
    end else begin
      $display("dma_scatter_gather_segment_builder test failed");
    end
    $finish;
  end

endmodule
